[sv/phantom_queue_ecn_marker_top_assert.svh]
// Assertion macros for the phantom queue marker RTL.
// Both macros sample on the rising edge of clock and hold off while reset is high.
`ifndef PHANTOM_QUEUE_ECN_MARKER_TOP_ASSERT_SVH
`define PHANTOM_QUEUE_ECN_MARKER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define PQEM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define PQEM_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);
`else
`define PQEM_ASSERT(lbl, prop, msg)
`define PQEM_NEVER(lbl, cond, msg)
`endif
`endif

[sv/pqem_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package pqem_pkg;

   // field widths
   localparam int PORT_W     = 5;
   localparam int TIME_W     = 48;
   localparam int LEN_W      = 24;
   localparam int GAMMA_W    = 16;
   localparam int FRAC_W     = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 24;

   // elapsed time is clamped to 2^34; split for two narrow multiplies
   localparam int ELAP_W    = 35;
   localparam int ELAP_LO_W = 17;
   localparam int ELAP_HI_W = ELAP_W - ELAP_LO_W;
   localparam logic [ELAP_W-1:0] ELAP_CAP = {1'b1, {(ELAP_W-1){1'b0}}};

   localparam logic [LEN_W-1:0] LEN_MAX = '1;

   // register reset values
   localparam logic [GAMMA_W-1:0] GAMMA_RESET  = 16'd62259;
   localparam logic [LEN_W-1:0]   THRESH_RESET = 24'd15000;

   // queue between front and back, and the result buffer
   localparam int QUEUE_DEPTH = 8;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int OUT_DEPTH   = 4;
   localparam int OCNT_W      = $clog2(OUT_DEPTH + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAMMA_FRAC   = 1'b0,
      CSR_THRESH_LEVEL = 1'b1
   } csr_index_type;

   // classified word handed from front to back
   typedef struct packed {
      logic [PORT_W-1:0] port;
      logic              in_range;
      logic              present;
      logic              drain_over;
      logic [LEN_W-1:0]  drain;
   } work_type;

   typedef struct packed {
      logic [PORT_W-1:0] out_port;
      logic              ecn_mark;
      logic [LEN_W-1:0]  phantom_len;
   } result_type;

endpackage
`default_nettype wire

[sv/pqem_chan_if.sv]
`timescale 1ns / 1ps
`default_nettype none

// request channel: one departure event per word
interface pqem_req_if;
   logic                        valid;
   logic                        ready;
   logic [pqem_pkg::PORT_W-1:0] port;
   logic [pqem_pkg::TIME_W-1:0] tstamp;
   logic                        pkt_present;

   modport source (output valid, output port, output tstamp, output pkt_present,
                   input ready);
   modport sink (input valid, input port, input tstamp, input pkt_present,
                 output ready);
endinterface

// response channel: one marking decision per word
interface pqem_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [pqem_pkg::PORT_W-1:0] out_port;
   logic                        ecn_mark;
   logic [pqem_pkg::LEN_W-1:0]  phantom_len;

   modport source (output valid, output out_port, output ecn_mark, output phantom_len,
                   input ready);
   modport sink (input valid, input out_port, input ecn_mark, input phantom_len,
                 output ready);
endinterface

`default_nettype wire

[sv/pqem_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module pqem_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input wire              clock,
   input wire              we,
   input wire [ADDR_W-1:0] waddr,
   input wire [WIDTH-1:0]  wdata,
   input wire [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one write port, one registered read port (read returns old data on collision)
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

[sv/pqem_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "phantom_queue_ecn_marker_top_assert.svh"
module pqem_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4,
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input wire              clock,
   input wire              reset,
   input wire              push,
   input wire [WIDTH-1:0]  push_data,
   input wire              pop,
   output logic [WIDTH-1:0] head_data,
   output logic            empty,
   output logic [CNT_W-1:0] count
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   assign empty     = (count_ff == '0);
   assign do_pop    = pop && !empty;
   assign head_data = mem_ff[rd_ptr_ff];
   assign count     = count_ff;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // the producer's credit check must keep the fifo from overflowing
   `PQEM_NEVER(a_fifo_overflow, push && (count_ff == CNT_W'(DEPTH)), "fifo push while full")
   `PQEM_NEVER(a_fifo_underflow, pop && empty, "fifo pop while empty")

endmodule
`default_nettype wire

[sv/pqem_front.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "phantom_queue_ecn_marker_top_assert.svh"
module pqem_front #(
   parameter int NUM_PORTS = 32,
   parameter int MTU_BYTES = 1500
) (
   input wire                               clock,
   input wire                               reset,
   pqem_req_if.sink                         req_ch,
   input wire [pqem_pkg::GAMMA_W-1:0]       gamma_frac,
   input wire [pqem_pkg::QCNT_W-1:0]        q_count,
   output logic                             q_push,
   output pqem_pkg::work_type               q_word
);

   localparam int PORT_W    = pqem_pkg::PORT_W;
   localparam int TIME_W    = pqem_pkg::TIME_W;
   localparam int LEN_W     = pqem_pkg::LEN_W;
   localparam int ELAP_W    = pqem_pkg::ELAP_W;
   localparam int ELAP_LO_W = pqem_pkg::ELAP_LO_W;
   localparam int QCNT_W    = pqem_pkg::QCNT_W;
   localparam int ADDR_W    = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
   localparam int CMP_W     = (PORT_W > $clog2(NUM_PORTS + 1)) ? PORT_W
                                                               : $clog2(NUM_PORTS + 1);
   localparam int MTU_W     = $clog2(MTU_BYTES + 1);
   localparam int RATE_W    = pqem_pkg::GAMMA_W + MTU_W;
   localparam int PLO_W     = RATE_W + ELAP_LO_W;
   localparam int PHI_W     = RATE_W + pqem_pkg::ELAP_HI_W;
   localparam int PROD_W    = RATE_W + ELAP_W;
   localparam int DRAIN_W   = PROD_W - pqem_pkg::FRAC_W;

   logic                rdy;
   logic                accept;
   logic [1:0]          in_flight;
   logic [QCNT_W:0]     q_used;
   logic [ADDR_W-1:0]   rd_addr;
   logic                rd_in_range;

   logic [RATE_W-1:0]   rate_ff, rate_in;

   // time store and its valid bits
   logic [NUM_PORTS-1:0] tvalid_ff, tvalid_in;
   logic                 tv_rd_ff;
   logic [TIME_W-1:0]    tm_rdata;
   logic                 tm_we;
   logic                 tb_v_ff;
   logic [ADDR_W-1:0]    tb_addr_ff;
   logic [TIME_W-1:0]    tb_time_ff;

   // stage 1: time lookup, elapsed
   logic                f1_v_ff;
   logic [PORT_W-1:0]   f1_port_ff;
   logic                f1_in_range_ff;
   logic                f1_present_ff;
   logic [TIME_W-1:0]   f1_time_ff;
   logic [ADDR_W-1:0]   f1_addr;
   logic [TIME_W-1:0]   last_time;
   logic [TIME_W:0]     diff;
   logic [ELAP_W-1:0]   elap;

   // stage 2: partial products
   logic                f2_v_ff;
   logic [PORT_W-1:0]   f2_port_ff;
   logic                f2_in_range_ff;
   logic                f2_present_ff;
   logic [ELAP_W-1:0]   f2_elap_ff;

   // stage 3: sum, drain
   logic                f3_v_ff;
   logic [PORT_W-1:0]   f3_port_ff;
   logic                f3_in_range_ff;
   logic                f3_present_ff;
   logic [PLO_W-1:0]    f3_plo_ff;
   logic [PHI_W-1:0]    f3_phi_ff;
   logic [PROD_W-1:0]   prod;
   logic [DRAIN_W-1:0]  drain_full;

   // accept only while the queue has room for everything in flight
   assign in_flight = {1'b0, f1_v_ff} + {1'b0, f2_v_ff} + {1'b0, f3_v_ff};
   assign q_used    = {1'b0, q_count} + (QCNT_W + 1)'(in_flight);
   assign rdy       = (q_used < (QCNT_W + 1)'(pqem_pkg::QUEUE_DEPTH));
   assign req_ch.ready = rdy;
   assign accept    = req_ch.valid && rdy;

   assign rd_addr     = ADDR_W'(req_ch.port);
   assign rd_in_range = (CMP_W'(req_ch.port) < CMP_W'(NUM_PORTS));

   // drain rate in bytes per time unit, Q.16
   assign rate_in = RATE_W'(gamma_frac) * RATE_W'(MTU_BYTES);

   pqem_ram #(
      .WIDTH (TIME_W),
      .DEPTH (NUM_PORTS)
   ) u_time_ram (
      .clock (clock),
      .we    (tm_we),
      .waddr (f1_addr),
      .wdata (f1_time_ff),
      .raddr (rd_addr),
      .rdata (tm_rdata)
   );

   // last update time, forwarding the write of the previous word
   assign f1_addr = ADDR_W'(f1_port_ff);
   assign tm_we   = f1_v_ff && f1_in_range_ff;

   always_comb begin
      if (tb_v_ff && (tb_addr_ff == f1_addr)) begin
         last_time = tb_time_ff;
      end else if (tv_rd_ff) begin
         last_time = tm_rdata;
      end else begin
         last_time = '0;
      end
      diff = {1'b0, f1_time_ff} - {1'b0, last_time};
      if (diff[TIME_W]) begin
         elap = '0;
      end else if (diff[TIME_W-1:ELAP_W-1] != '0) begin
         elap = pqem_pkg::ELAP_CAP;
      end else begin
         elap = {1'b0, diff[ELAP_W-2:0]};
      end
   end

   always_comb begin
      tvalid_in = tvalid_ff;
      if (tm_we) begin
         tvalid_in[f1_addr] = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         f1_v_ff   <= 1'b0;
         f2_v_ff   <= 1'b0;
         f3_v_ff   <= 1'b0;
         tvalid_ff <= '0;
         tb_v_ff   <= 1'b0;
      end else begin
         f1_v_ff   <= accept;
         f2_v_ff   <= f1_v_ff;
         f3_v_ff   <= f2_v_ff;
         tvalid_ff <= tvalid_in;
         if (tm_we) begin
            tb_v_ff <= 1'b1;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rate_ff  <= rate_in;
      tv_rd_ff <= tvalid_ff[rd_addr];
      if (tm_we) begin
         tb_addr_ff <= f1_addr;
         tb_time_ff <= f1_time_ff;
      end
      f1_port_ff     <= req_ch.port;
      f1_in_range_ff <= rd_in_range;
      f1_present_ff  <= req_ch.pkt_present;
      f1_time_ff     <= req_ch.tstamp;
      f2_port_ff     <= f1_port_ff;
      f2_in_range_ff <= f1_in_range_ff;
      f2_present_ff  <= f1_present_ff;
      f2_elap_ff     <= elap;
      f3_port_ff     <= f2_port_ff;
      f3_in_range_ff <= f2_in_range_ff;
      f3_present_ff  <= f2_present_ff;
      f3_plo_ff      <= PLO_W'(rate_ff) * PLO_W'(f2_elap_ff[ELAP_LO_W-1:0]);
      f3_phi_ff      <= PHI_W'(rate_ff) * PHI_W'(f2_elap_ff[ELAP_W-1:ELAP_LO_W]);
   end

   // combine partial products, drop the fraction, flag a drain beyond the length range
   assign prod       = PROD_W'(f3_plo_ff) + (PROD_W'(f3_phi_ff) << ELAP_LO_W);
   assign drain_full = prod[PROD_W-1:pqem_pkg::FRAC_W];

   assign q_push            = f3_v_ff;
   assign q_word.port       = f3_port_ff;
   assign q_word.in_range   = f3_in_range_ff;
   assign q_word.present    = f3_present_ff;
   assign q_word.drain_over = (drain_full[DRAIN_W-1:LEN_W] != '0);
   assign q_word.drain      = drain_full[LEN_W-1:0];

   // back-to-back words on one port must see the time just written
   `PQEM_ASSERT(a_time_forward,
      f1_v_ff && f1_in_range_ff && $past(tm_we) && ($past(f1_addr) == f1_addr)
      |-> (last_time == $past(f1_time_ff)),
      "time forwarding returned a stale update time")

endmodule
`default_nettype wire

[sv/pqem_back.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "phantom_queue_ecn_marker_top_assert.svh"
module pqem_back #(
   parameter int NUM_PORTS = 32,
   parameter int MTU_BYTES = 1500
) (
   input wire                         clock,
   input wire                         reset,
   input wire                         q_empty,
   input wire pqem_pkg::work_type     q_head,
   output logic                       q_pop,
   input wire [pqem_pkg::LEN_W-1:0]   thresh_level,
   input wire [pqem_pkg::OCNT_W-1:0]  out_count,
   output logic                       out_push,
   output pqem_pkg::result_type       out_word
);

   localparam int LEN_W  = pqem_pkg::LEN_W;
   localparam int OCNT_W = pqem_pkg::OCNT_W;
   localparam int ADDR_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
   localparam logic [LEN_W-1:0] MTU_LEN = LEN_W'(MTU_BYTES);

   logic [ADDR_W-1:0]    rd_addr;
   logic [OCNT_W:0]      out_used;

   // length store and its valid bits
   logic [NUM_PORTS-1:0] lvalid_ff, lvalid_in;
   logic                 lv_rd_ff;
   logic [LEN_W-1:0]     len_rdata;
   logic                 len_we;
   logic                 lb_v_ff;
   logic [ADDR_W-1:0]    lb_addr_ff;
   logic [LEN_W-1:0]     lb_len_ff;

   // apply stage
   logic                 b1_v_ff;
   pqem_pkg::work_type   b1_work_ff;
   logic [ADDR_W-1:0]    b1_addr;
   logic [LEN_W-1:0]     len_old;
   logic [LEN_W-1:0]     len_drained;
   logic [LEN_W:0]       len_sum;
   logic [LEN_W-1:0]     len_new;
   logic                 mark;

   // pop only when the result buffer can take the word
   assign out_used = {1'b0, out_count} + (OCNT_W + 1)'(b1_v_ff);
   assign q_pop    = !q_empty && (out_used < (OCNT_W + 1)'(pqem_pkg::OUT_DEPTH));
   assign rd_addr  = ADDR_W'(q_head.port);

   pqem_ram #(
      .WIDTH (LEN_W),
      .DEPTH (NUM_PORTS)
   ) u_len_ram (
      .clock (clock),
      .we    (len_we),
      .waddr (b1_addr),
      .wdata (len_new),
      .raddr (rd_addr),
      .rdata (len_rdata)
   );

   assign b1_addr = ADDR_W'(b1_work_ff.port);
   assign len_we  = b1_v_ff && b1_work_ff.in_range;

   // drain, add one MTU on departure, mark
   always_comb begin
      if (lb_v_ff && (lb_addr_ff == b1_addr)) begin
         len_old = lb_len_ff;
      end else if (lv_rd_ff) begin
         len_old = len_rdata;
      end else begin
         len_old = '0;
      end
      if (b1_work_ff.drain_over || (b1_work_ff.drain >= len_old)) begin
         len_drained = '0;
      end else begin
         len_drained = len_old - b1_work_ff.drain;
      end
      len_sum = {1'b0, len_drained} + {1'b0, MTU_LEN};
      if (!b1_work_ff.present) begin
         len_new = len_drained;
      end else if (len_sum[LEN_W]) begin
         len_new = pqem_pkg::LEN_MAX;
      end else begin
         len_new = len_sum[LEN_W-1:0];
      end
      mark = b1_work_ff.present && (len_new > thresh_level);
   end

   always_comb begin
      lvalid_in = lvalid_ff;
      if (len_we) begin
         lvalid_in[b1_addr] = 1'b1;
      end
   end

   // result word; ports outside the table report zero and leave no trace
   assign out_push             = b1_v_ff;
   assign out_word.out_port    = b1_work_ff.port;
   assign out_word.ecn_mark    = b1_work_ff.in_range && mark;
   assign out_word.phantom_len = b1_work_ff.in_range ? len_new : '0;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         b1_v_ff   <= 1'b0;
         lvalid_ff <= '0;
         lb_v_ff   <= 1'b0;
      end else begin
         b1_v_ff   <= q_pop;
         lvalid_ff <= lvalid_in;
         if (len_we) begin
            lb_v_ff <= 1'b1;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      lv_rd_ff   <= lvalid_ff[rd_addr];
      b1_work_ff <= q_head;
      if (len_we) begin
         lb_addr_ff <= b1_addr;
         lb_len_ff  <= len_new;
      end
   end

   // a word right behind one on the same port must start from its new length
   `PQEM_ASSERT(a_len_forward,
      b1_v_ff && b1_work_ff.in_range && $past(len_we) && ($past(b1_addr) == b1_addr)
      |-> (len_old == $past(len_new)),
      "length forwarding returned a stale length")
   // a departure always leaves at least one MTU in the phantom queue
   `PQEM_ASSERT(a_depart_min,
      out_push && b1_work_ff.in_range && b1_work_ff.present
      |-> (out_word.phantom_len >= MTU_LEN),
      "departure left less than one MTU")
   // without a departure the length can only drain
   `PQEM_ASSERT(a_idle_drains,
      out_push && b1_work_ff.in_range && !b1_work_ff.present
      |-> ((out_word.phantom_len <= len_old) && !out_word.ecn_mark),
      "length grew or marked without a departure")

endmodule
`default_nettype wire

[sv/phantom_queue_ecn_marker_top.sv]
// Path: front stages f1, f2, f3, the queue, the back's apply stage, the response buffer.
// Throughput: one word per cycle while rsp_ch.ready holds, also back-to-back on one port.
// The rate is set by the per-port length read-modify-write in the back stage, which
//   forwards its own last write so the next word can follow in the next cycle.
// Reset (synchronous, active high): all ports read length 0 and time 0 at once through
//   valid bits, no clearing pass; gamma_frac returns to 62259 and the mark threshold to 15000.
`timescale 1ns / 1ps
`default_nettype none
module phantom_queue_ecn_marker_top #(
   parameter int NUM_PORTS = 32,
   parameter int MTU_BYTES = 1500
) (
   input wire                                clock,
   input wire                                reset,
   pqem_req_if.sink                          req_ch,
   pqem_rsp_if.source                        rsp_ch,
   input wire                                csr_we,
   input wire [pqem_pkg::CSR_IDX_W-1:0]      csr_index,
   input wire [pqem_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int GAMMA_W = pqem_pkg::GAMMA_W;
   localparam int LEN_W   = pqem_pkg::LEN_W;

   logic [GAMMA_W-1:0]         gamma_ff, gamma_in;
   logic [LEN_W-1:0]           thresh_ff, thresh_in;

   logic                       q_push;
   logic                       q_pop;
   logic                       q_empty;
   pqem_pkg::work_type         q_word;
   pqem_pkg::work_type         q_head;
   logic [pqem_pkg::QCNT_W-1:0] q_count;

   logic                       out_push;
   logic                       out_pop;
   logic                       out_empty;
   pqem_pkg::result_type       out_word;
   pqem_pkg::result_type       out_head;
   logic [pqem_pkg::OCNT_W-1:0] out_count;

   // configuration registers
   always_comb begin
      gamma_in  = gamma_ff;
      thresh_in = thresh_ff;
      if (csr_we) begin
         case (pqem_pkg::csr_index_type'(csr_index))
            pqem_pkg::CSR_GAMMA_FRAC:   gamma_in  = csr_wdata[GAMMA_W-1:0];
            pqem_pkg::CSR_THRESH_LEVEL: thresh_in = csr_wdata[LEN_W-1:0];
            default: begin
               gamma_in  = gamma_ff;
               thresh_in = thresh_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gamma_ff  <= pqem_pkg::GAMMA_RESET;
         thresh_ff <= pqem_pkg::THRESH_RESET;
      end else begin
         gamma_ff  <= gamma_in;
         thresh_ff <= thresh_in;
      end
   end

   // front: accept, time lookup, drain amount
   pqem_front #(
      .NUM_PORTS (NUM_PORTS),
      .MTU_BYTES (MTU_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .gamma_frac (gamma_ff),
      .q_count    (q_count),
      .q_push     (q_push),
      .q_word     (q_word)
   );

   // decoupling queue
   pqem_fifo #(
      .WIDTH ($bits(pqem_pkg::work_type)),
      .DEPTH (pqem_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_word),
      .pop       (q_pop),
      .head_data (q_head),
      .empty     (q_empty),
      .count     (q_count)
   );

   // back: length update and marking
   pqem_back #(
      .NUM_PORTS (NUM_PORTS),
      .MTU_BYTES (MTU_BYTES)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (q_empty),
      .q_head       (q_head),
      .q_pop        (q_pop),
      .thresh_level (thresh_ff),
      .out_count    (out_count),
      .out_push     (out_push),
      .out_word     (out_word)
   );

   // response buffer
   pqem_fifo #(
      .WIDTH ($bits(pqem_pkg::result_type)),
      .DEPTH (pqem_pkg::OUT_DEPTH)
   ) u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_word),
      .pop       (out_pop),
      .head_data (out_head),
      .empty     (out_empty),
      .count     (out_count)
   );

   assign out_pop            = !out_empty && rsp_ch.ready;
   assign rsp_ch.valid       = !out_empty;
   assign rsp_ch.out_port    = out_head.out_port;
   assign rsp_ch.ecn_mark    = out_head.ecn_mark;
   assign rsp_ch.phantom_len = out_head.phantom_len;

endmodule
`default_nettype wire
